FILE: design/ifd_pkg.sv
// shared types and constants for the inertial sensor frame deframer
package ifd_pkg;

  localparam int NumFields  = 16;
  localparam int FidxW      = 4;
  localparam int FieldW     = 24;
  localparam int PosW       = 6;
  localparam int ValueW     = 32;
  localparam int NumBanks   = 2;
  localparam int StoreAddrW = FidxW + 1;
  localparam int CmdqDepth  = 2;
  localparam int OutqDepth  = 4;
  localparam int OutqPtrW   = 2;
  localparam int OutqCntW   = 3;

  // frame positions
  localparam logic [PosW-1:0] POS_FIELD_END = 6'd48;
  localparam logic [PosW-1:0] POS_CHECK_END = 6'd51;

  // frame status codes
  localparam logic [1:0] ST_GOOD      = 2'd0;
  localparam logic [1:0] ST_BAD_TAIL  = 2'd1;
  localparam logic [1:0] ST_BAD_CHECK = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_HEADER   = 2'd0;
  localparam logic [1:0] REG_TAIL     = 2'd1;
  localparam logic [1:0] REG_OFFSET   = 2'd2;
  localparam logic [1:0] REG_EXPECTED = 2'd3;

  localparam logic [7:0]        HEADER_RST   = 8'h50;
  localparam logic [7:0]        TAIL_RST     = 8'h0d;
  localparam logic [FieldW-1:0] OFFSET_RST   = 24'd1000000;
  localparam logic [FieldW-1:0] EXPECTED_RST = 24'd1128000;

  localparam logic signed [ValueW-1:0] ACCEL_SCALE = 32'sd98;

  // judged frame handed from front to back
  typedef struct packed {
    logic [1:0] status;
    logic       bank;
  } cmd_t;

  // field store write from the front
  typedef struct packed {
    logic                  en;
    logic [StoreAddrW-1:0] addr;
    logic [FieldW-1:0]     data;
  } store_wr_t;

  // bank handed back once its last read is issued
  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

  typedef struct packed {
    logic [FidxW-1:0]         field_index;
    logic signed [ValueW-1:0] field_value;
    logic [1:0]               frame_status;
    logic                     last;
  } res_t;

endpackage

FILE: design/ifd_front.sv
// byte parser: frame hunting, field assembly, store writes and frame judging
module ifd_front import ifd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_rx_byte,
  input  logic [7:0]        header_byte,
  input  logic [7:0]        tail_byte,
  input  logic [FieldW-1:0] expected_check,
  input  logic              cmdq_full,
  output logic              cmd_push,
  output cmd_t              cmd,
  output store_wr_t         store_wr,
  input  bank_rel_t         bank_rel
);

  logic                in_frame_r, in_frame_nxt;
  logic [PosW-1:0]     pos_r, pos_nxt;
  logic [1:0]          sub_r, sub_nxt;
  logic [FidxW-1:0]    fidx_r, fidx_nxt;
  logic [15:0]         partial_r, partial_nxt;
  logic [FieldW-1:0]   check_r, check_nxt;
  logic                wbank_r, wbank_nxt;
  logic [NumBanks-1:0] busy_r, busy_nxt;
  logic                accept;
  logic [PosW-1:0]     p;

  // a frame in progress waits while its bank still drains or the queue is full
  assign in_full = in_frame_r && (busy_r[wbank_r] || cmdq_full);
  assign accept  = in_push && !in_full;
  assign p       = pos_r + 6'd1;

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    sub_nxt      = sub_r;
    fidx_nxt     = fidx_r;
    partial_nxt  = partial_r;
    check_nxt    = check_r;
    wbank_nxt    = wbank_r;
    busy_nxt     = busy_r;
    cmd_push     = 1'b0;
    cmd.status   = ST_GOOD;
    cmd.bank     = wbank_r;
    store_wr.en   = 1'b0;
    store_wr.addr = {wbank_r, fidx_r};
    store_wr.data = {partial_r, in_rx_byte};
    if (bank_rel.en) begin
      busy_nxt[bank_rel.bank] = 1'b0;
    end
    if (accept) begin
      if (!in_frame_r) begin
        if (in_rx_byte == header_byte) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = '0;
          sub_nxt      = 2'd0;
          fidx_nxt     = '0;
          partial_nxt  = '0;
        end
      end else begin
        pos_nxt = p;
        if (p <= POS_FIELD_END) begin
          case (sub_r)
            2'd0: begin
              partial_nxt = {8'd0, in_rx_byte};
              sub_nxt     = 2'd1;
            end
            2'd1: begin
              partial_nxt = {partial_r[7:0], in_rx_byte};
              sub_nxt     = 2'd2;
            end
            default: begin
              store_wr.en = 1'b1;
              fidx_nxt    = fidx_r + 4'd1;
              sub_nxt     = 2'd0;
            end
          endcase
        end else if (p <= POS_CHECK_END) begin
          check_nxt = {check_r[15:0], in_rx_byte};
        end else begin
          in_frame_nxt = 1'b0;
          pos_nxt      = '0;
          partial_nxt  = '0;
          cmd_push     = 1'b1;
          if (in_rx_byte != tail_byte) begin
            cmd.status = ST_BAD_TAIL;
          end else if (check_r != expected_check) begin
            cmd.status = ST_BAD_CHECK;
          end else begin
            cmd.status        = ST_GOOD;
            busy_nxt[wbank_r] = 1'b1;
            wbank_nxt         = ~wbank_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      sub_r      <= 2'd0;
      fidx_r     <= '0;
      partial_r  <= '0;
      check_r    <= '0;
      wbank_r    <= 1'b0;
      busy_r     <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      sub_r      <= sub_nxt;
      fidx_r     <= fidx_nxt;
      partial_r  <= partial_nxt;
      check_r    <= check_nxt;
      wbank_r    <= wbank_nxt;
      busy_r     <= busy_nxt;
    end
  end

endmodule

FILE: design/ifd_cmdq.sv
// two-entry queue of judged frames between front and back
module ifd_cmdq import ifd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t       mem_r [CmdqDepth];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'(CmdqDepth));
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: design/ifd_back.sv
// field store, result sequencer, scaling pipeline and result queue
module ifd_back import ifd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [FieldW-1:0] field_offset,
  input  store_wr_t         store_wr,
  input  logic              cmdq_empty,
  input  cmd_t              cmdq_data,
  output logic              cmdq_pop,
  output bank_rel_t         bank_rel,
  output logic              out_empty,
  input  logic              out_pop,
  output res_t              out_res
);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_RUN  = 1'b1;

  logic [FieldW-1:0] store_r [NumBanks * NumFields];

  logic             state_r, state_nxt;
  logic [FidxW-1:0] idx_r, idx_nxt;
  logic [1:0]       cur_status_r, cur_status_nxt;
  logic             cur_bank_r, cur_bank_nxt;
  logic             issue, issue_last;

  // stage 1: store read
  logic              s1_v_r;
  logic [FieldW-1:0] s1_data_r;
  logic [FidxW-1:0]  s1_idx_r;
  logic [1:0]        s1_status_r;
  logic              s1_last_r;
  // stage 2: offset removed
  logic               s2_v_r;
  logic signed [24:0] s2_diff_r, s2_diff_nxt;
  logic [FidxW-1:0]   s2_idx_r;
  logic [1:0]         s2_status_r;
  logic               s2_last_r;
  // stage 3: scaled value, pushed into the result queue
  logic                     s3_v_r;
  res_t                     s3_res_r;
  logic signed [ValueW-1:0] diff_ext, value_nxt;

  res_t                outq_r [OutqDepth];
  logic [OutqPtrW-1:0] owptr_r, orptr_r;
  logic [OutqCntW-1:0] ocnt_r, ocnt_nxt;
  logic                opop;
  logic [OutqCntW:0]   pending;

  // results in flight plus waiting must fit the queue
  assign pending = {1'b0, ocnt_r} + {3'd0, s1_v_r} + {3'd0, s2_v_r} + {3'd0, s3_v_r};
  assign issue   = (state_r == B_RUN) && (pending < 4'(OutqDepth));
  assign issue_last = (cur_status_r != ST_GOOD) || (idx_r == 4'(NumFields - 1));

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cur_status_nxt = cur_status_r;
    cur_bank_nxt   = cur_bank_r;
    cmdq_pop       = 1'b0;
    bank_rel.en    = 1'b0;
    bank_rel.bank  = cur_bank_r;
    case (state_r)
      B_IDLE: begin
        if (!cmdq_empty) begin
          cmdq_pop       = 1'b1;
          cur_status_nxt = cmdq_data.status;
          cur_bank_nxt   = cmdq_data.bank;
          idx_nxt        = '0;
          state_nxt      = B_RUN;
        end
      end
      B_RUN: begin
        if (issue) begin
          if (issue_last) begin
            state_nxt   = B_IDLE;
            bank_rel.en = (cur_status_r == ST_GOOD);
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store_r[store_wr.addr] <= store_wr.data;
    end
    if (issue) begin
      s1_data_r <= store_r[{cur_bank_r, idx_r}];
    end
  end

  always_comb begin
    s2_diff_nxt = $signed({1'b0, s1_data_r}) - $signed({1'b0, field_offset});
    if (s1_status_r != ST_GOOD) begin
      s2_diff_nxt = '0;
    end
    diff_ext = {{(ValueW - 25){s2_diff_r[24]}}, s2_diff_r};
    if (s2_idx_r inside {[4'd3:4'd5]}) begin
      value_nxt = diff_ext * ACCEL_SCALE;
    end else if (s2_idx_r inside {[4'd9:4'd11]}) begin
      value_nxt = -diff_ext;
    end else begin
      value_nxt = diff_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_idx_r    <= (cur_status_r == ST_GOOD) ? idx_r : '0;
      s1_status_r <= cur_status_r;
      s1_last_r   <= issue_last;
    end
    s2_diff_r   <= s2_diff_nxt;
    s2_idx_r    <= s1_idx_r;
    s2_status_r <= s1_status_r;
    s2_last_r   <= s1_last_r;
    s3_res_r.field_index  <= s2_idx_r;
    s3_res_r.field_value  <= value_nxt;
    s3_res_r.frame_status <= s2_status_r;
    s3_res_r.last         <= s2_last_r;
  end

  // result queue
  assign out_empty = (ocnt_r == '0);
  assign opop      = out_pop && !out_empty;
  assign out_res   = outq_r[orptr_r];

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (s3_v_r && !opop) begin
      ocnt_nxt = ocnt_r + 3'd1;
    end else if (opop && !s3_v_r) begin
      ocnt_nxt = ocnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      outq_r[owptr_r] <= s3_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      idx_r        <= '0;
      cur_status_r <= ST_GOOD;
      cur_bank_r   <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      owptr_r      <= '0;
      orptr_r      <= '0;
      ocnt_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      cur_status_r <= cur_status_nxt;
      cur_bank_r   <= cur_bank_nxt;
      s1_v_r       <= issue;
      s2_v_r       <= s1_v_r;
      s3_v_r       <= s2_v_r;
      owptr_r      <= s3_v_r ? owptr_r + 2'd1 : owptr_r;
      orptr_r      <= opop ? orptr_r + 2'd1 : orptr_r;
      ocnt_r       <= ocnt_nxt;
    end
  end

endmodule

FILE: design/imu_frame_deframer_core.sv
// top level of the inertial sensor frame deframer
//
// Takes one received byte per transfer and hunts for 53-byte frames (header,
// sixteen 24-bit big-endian fields, a 24-bit check field, tail byte). Bytes
// are refused only inside a frame while the store bank it fills is still being
// read out or two judged frames wait in the frame queue. The field store has
// two banks, so a new frame fills one while the last good frame is read from
// the other. A good frame gives its sixteen results, each passing from its
// store read through the offset and scaling stages into the result queue; a
// bad frame gives one error result. Store reads are paced by a credit check
// that counts results in flight and waiting against the four-entry result
// queue, so a read is issued only while that queue has room for its result.
// Configuration writes are registered.
module imu_frame_deframer_core import ifd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_rx_byte,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [FidxW-1:0]  out_field_index,
  output logic signed [ValueW-1:0] out_field_value,
  output logic [1:0]        out_frame_status,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [FieldW-1:0] cfg_wdata
);

  logic [7:0]        header_r;
  logic [7:0]        tail_r;
  logic [FieldW-1:0] offset_r;
  logic [FieldW-1:0] expected_r;

  logic      cmdq_full, cmdq_empty, cmd_push, cmdq_pop;
  cmd_t      cmd, cmdq_data;
  store_wr_t store_wr;
  bank_rel_t bank_rel;
  res_t      out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r   <= HEADER_RST;
      tail_r     <= TAIL_RST;
      offset_r   <= OFFSET_RST;
      expected_r <= EXPECTED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER:   header_r   <= cfg_wdata[7:0];
        REG_TAIL:     tail_r     <= cfg_wdata[7:0];
        REG_OFFSET:   offset_r   <= cfg_wdata;
        REG_EXPECTED: expected_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ifd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_rx_byte     (in_rx_byte),
    .header_byte    (header_r),
    .tail_byte      (tail_r),
    .expected_check (expected_r),
    .cmdq_full      (cmdq_full),
    .cmd_push       (cmd_push),
    .cmd            (cmd),
    .store_wr       (store_wr),
    .bank_rel       (bank_rel)
  );

  ifd_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd),
    .full      (cmdq_full),
    .pop       (cmdq_pop),
    .pop_data  (cmdq_data),
    .empty     (cmdq_empty)
  );

  ifd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .field_offset (offset_r),
    .store_wr     (store_wr),
    .cmdq_empty   (cmdq_empty),
    .cmdq_data    (cmdq_data),
    .cmdq_pop     (cmdq_pop),
    .bank_rel     (bank_rel),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_res      (out_res)
  );

  assign out_field_index  = out_res.field_index;
  assign out_field_value  = out_res.field_value;
  assign out_frame_status = out_res.frame_status;
  assign out_last         = out_res.last;

endmodule
